// ----- rtl/vfa_pkg.sv -----
// Shared widths, opcodes, types and saturation helpers of the vector ALU.
package vfa_pkg;

  localparam int CW = 32;          // component width
  localparam int FB = 16;          // fraction bits
  localparam int PW = 2 * CW;      // product width
  localparam int SW = PW + 2;      // sum of three products
  localparam int MW = CW;          // square root width
  localparam int NW = CW + FB;     // dividend / quotient width

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DOT   = 3'd3;
  localparam logic [2:0] OP_CROSS = 3'd4;
  localparam logic [2:0] OP_MAG   = 3'd5;
  localparam logic [2:0] OP_NORM  = 3'd6;

  typedef logic signed [CW-1:0] comp_t;

  localparam comp_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam comp_t CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    comp_t val;
    logic  ov;
  } sat_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t s;
    logic  ov;
    logic  zv;
  } bun_t;

  typedef struct packed {
    logic [2:0] op;
    comp_t      a_x;
    comp_t      a_y;
    comp_t      a_z;
  } ctl_t;

  // Clamp a wide signed value to the component range
  function automatic sat_t sat_wide(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    sat_t r;
    hi = SW'(CMAX);
    lo = SW'(CMIN);
    if (v > hi) begin
      r.val = CMAX;
      r.ov  = 1'b1;
    end else if (v < lo) begin
      r.val = CMIN;
      r.ov  = 1'b1;
    end else begin
      r.val = comp_t'(v[CW-1:0]);
      r.ov  = 1'b0;
    end
    return r;
  endfunction

  // Apply sign to an unsigned quotient and clamp
  function automatic sat_t sat_quot(input logic [NW-1:0] q, input logic neg);
    logic [NW-1:0] lim_p;
    logic [NW-1:0] lim_n;
    sat_t r;
    lim_p = NW'(CMAX);
    lim_n = NW'(1) << (CW - 1);
    r.ov  = 1'b0;
    if (!neg) begin
      if (q > lim_p) begin
        r.val = CMAX;
        r.ov  = 1'b1;
      end else begin
        r.val = comp_t'(q[CW-1:0]);
      end
    end else begin
      if (q > lim_n) begin
        r.val = CMIN;
        r.ov  = 1'b1;
      end else begin
        r.val = comp_t'(CW'(0) - q[CW-1:0]);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/vfa_lane.sv -----
// One component lane: operand selection, two multipliers and the lane combine.
module vfa_lane import vfa_pkg::*; (
  input  logic                 clk,
  input  logic [2:0]           op,
  input  comp_t                a_i,
  input  comp_t                b_i,
  input  comp_t                a_j,
  input  comp_t                b_j,
  input  comp_t                a_k,
  input  comp_t                b_k,
  input  comp_t                s,
  output logic signed [SW-1:0] val
);

  comp_t m1a, m1b, m2a, m2b;
  logic signed [PW-1:0] p1_r, p2_r;
  logic signed [CW:0]   as_r;
  logic [2:0]           op_r;
  logic signed [SW-1:0] val_r;

  // Select multiplicands per operation
  always_comb begin
    m1a = a_i;
    m1b = b_i;
    m2a = '0;
    m2b = '0;
    unique case (op)
      OP_SCALE: m1b = s;
      OP_CROSS: begin
        m1a = a_j;
        m1b = b_k;
        m2a = a_k;
        m2b = b_j;
      end
      OP_MAG, OP_NORM: m1b = a_i;
      default: ;
    endcase
  end

  // Multiply, and form the exact sum or difference
  always_ff @(posedge clk) begin
    p1_r <= m1a * m1b;
    p2_r <= m2a * m2b;
    as_r <= (op == OP_SUB) ? ((CW+1)'(a_i) - (CW+1)'(b_i))
                           : ((CW+1)'(a_i) + (CW+1)'(b_i));
    op_r <= op;
  end

  // Combine the lane's products, or pass on the sum or difference
  always_ff @(posedge clk) begin
    unique case (op_r)
      OP_ADD, OP_SUB: val_r <= SW'(as_r);
      OP_CROSS:       val_r <= SW'(p1_r) - SW'(p2_r);
      default:        val_r <= SW'(p1_r);
    endcase
  end

  assign val = val_r;

endmodule

// ----- rtl/vfa_merge.sv -----
// Merge stage: sums the lanes, rescales, saturates and forms the early result.
module vfa_merge import vfa_pkg::*; (
  input  logic                 clk,
  input  logic [2:0]           op,
  input  logic signed [SW-1:0] v0,
  input  logic signed [SW-1:0] v1,
  input  logic signed [SW-1:0] v2,
  output bun_t                 bun,
  output logic [PW-1:0]        rad
);

  logic signed [SW-1:0] sum_r, v0_r, v1_r, v2_r;
  logic [2:0]           op_r;
  bun_t                 bun_nxt, bun_r;
  logic [PW-1:0]        rad_r;
  sat_t                 sx, sy, sz, ss;

  // Add the three lanes
  always_ff @(posedge clk) begin
    sum_r <= v0 + v1 + v2;
    v0_r  <= v0;
    v1_r  <= v1;
    v2_r  <= v2;
    op_r  <= op;
  end

  // Rescale and clamp per operation
  always_comb begin
    sx = '0;
    sy = '0;
    sz = '0;
    ss = '0;
    unique case (op_r)
      OP_ADD, OP_SUB: begin
        sx = sat_wide(v0_r);
        sy = sat_wide(v1_r);
        sz = sat_wide(v2_r);
      end
      OP_SCALE, OP_CROSS: begin
        sx = sat_wide(v0_r >>> FB);
        sy = sat_wide(v1_r >>> FB);
        sz = sat_wide(v2_r >>> FB);
      end
      OP_DOT: ss = sat_wide(sum_r >>> FB);
      default: ;
    endcase
    bun_nxt.x  = sx.val;
    bun_nxt.y  = sy.val;
    bun_nxt.z  = sz.val;
    bun_nxt.s  = ss.val;
    bun_nxt.ov = sx.ov | sy.ov | sz.ov | ss.ov;
    bun_nxt.zv = 1'b0;
  end

  always_ff @(posedge clk) begin
    bun_r <= bun_nxt;
    rad_r <= sum_r[PW-1:0];
  end

  assign bun = bun_r;
  assign rad = rad_r;

endmodule

// ----- rtl/vfa_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module vfa_sqrt import vfa_pkg::*; (
  input  logic          clk,
  input  logic [PW-1:0] rad,
  output logic [MW-1:0] root
);

  logic [MW:0]   rem_r  [MW];
  logic [MW-1:0] root_r [MW];
  logic [PW-1:0] n_r    [MW];

  for (genvar g = 0; g < MW; g++) begin : g_st
    logic [MW:0]   rem_p;
    logic [MW-1:0] root_p;
    logic [PW-1:0] n_p;
    logic [MW+1:0] rem_in, trial;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign n_p    = rad;
    end else begin : g_next
      assign rem_p  = rem_r[g-1];
      assign root_p = root_r[g-1];
      assign n_p    = n_r[g-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem_in = {rem_p[MW-1:0], n_p[PW-1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = rem_in >= trial;

    always_ff @(posedge clk) begin
      rem_r[g]  <= ge ? (MW+1)'(rem_in - trial) : rem_in[MW:0];
      root_r[g] <= {root_p[MW-2:0], ge};
      n_r[g]    <= n_p << 2;
    end
  end

  assign root = root_r[MW-1];

endmodule

// ----- rtl/vfa_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module vfa_div import vfa_pkg::*; (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [MW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [MW-1:0] rem_r [NW];
  logic [MW-1:0] den_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] q_r   [NW];

  for (genvar g = 0; g < NW; g++) begin : g_st
    logic [MW-1:0] rem_p, den_p;
    logic [NW-1:0] num_p, q_p;
    logic [MW:0]   rem_in;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_p = '0;
      assign den_p = den;
      assign num_p = num;
      assign q_p   = '0;
    end else begin : g_next
      assign rem_p = rem_r[g-1];
      assign den_p = den_r[g-1];
      assign num_p = num_r[g-1];
      assign q_p   = q_r[g-1];
    end

    // Shift in the next dividend bit and subtract where it fits
    assign rem_in = {rem_p, num_p[NW-1]};
    assign ge     = rem_in >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      rem_r[g] <= ge ? MW'(rem_in - {1'b0, den_p}) : rem_in[MW-1:0];
      den_r[g] <= den_p;
      num_r[g] <= num_p << 1;
      q_r[g]   <= {q_p[NW-2:0], ge};
    end
  end

  assign quo = q_r[NW-1];

endmodule

// ----- rtl/vec3_fixed_point_alu_core.sv -----
// Top level of the three-component Q16.16 vector ALU.
//
// Command channel: an operation transfers at a rising edge where start is
// high and busy is low. busy is high only while reset is held; otherwise the
// unit is fully pipelined and takes one operation every cycle.
// Result channel: out_valid is high for exactly one cycle with the result
// fields; the receiver takes it in that cycle and cannot stall the unit.
// Every opcode takes the same path: three component lanes of two 32x32
// multipliers, a merge stage, a 32-stage square root pipeline and three
// 48-stage divider pipelines; scalar and vector ops ride the same pipe so
// results leave in order.
// Throughput: one operation per cycle.
// Reset (synchronous, rst_n low) drops every operation in flight; no
// result appears for them. Operands carry no state between operations.
module vec3_fixed_point_alu_core import vfa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_op,
  input  comp_t      in_a_x,
  input  comp_t      in_a_y,
  input  comp_t      in_a_z,
  input  comp_t      in_b_x,
  input  comp_t      in_b_y,
  input  comp_t      in_b_z,
  input  comp_t      in_scale_factor,
  output logic       out_valid,
  output comp_t      out_res_x,
  output comp_t      out_res_y,
  output comp_t      out_res_z,
  output comp_t      out_res_scalar,
  output logic       out_overflow,
  output logic       out_zero_vector
);

  localparam int ROOT_IDX = 5 + MW;
  localparam int LAST     = ROOT_IDX + NW;
  localparam int LAT      = LAST + 2;

  logic [LAST:0] vld_r;
  ctl_t          ctl_r [LAST+1];
  bun_t          bun_r [5:LAST];
  comp_t         b_x_r, b_y_r, b_z_r, s_r;

  logic signed [SW-1:0] lv0, lv1, lv2;
  bun_t                 mrg_bun, root_bun;
  logic [PW-1:0]        rad;
  logic [MW-1:0]        root, den_r;
  logic [NW-1:0]        num_r [3];
  logic [NW-1:0]        quo   [3];
  ctl_t                 rc;
  comp_t                abs_x, abs_y, abs_z;
  sat_t                 fx, fy, fz;

  bun_t  out_nxt;
  bun_t  out_r;
  logic  out_valid_r;

  // Refuse commands while reset is held
  assign busy = ~rst_n;

  // Track which stages hold a live operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[LAST-1:0], start & ~busy};
      out_valid_r <= vld_r[LAST];
    end
  end

  // Capture operands and carry opcode and vector a along the pipe
  always_ff @(posedge clk) begin
    ctl_r[0].op  <= in_op;
    ctl_r[0].a_x <= in_a_x;
    ctl_r[0].a_y <= in_a_y;
    ctl_r[0].a_z <= in_a_z;
    b_x_r        <= in_b_x;
    b_y_r        <= in_b_y;
    b_z_r        <= in_b_z;
    s_r          <= in_scale_factor;
    for (int k = 1; k <= LAST; k++) begin
      ctl_r[k] <= ctl_r[k-1];
    end
  end

  vfa_lane u_lane_x (
    .clk (clk), .op (ctl_r[0].op),
    .a_i (ctl_r[0].a_x), .b_i (b_x_r),
    .a_j (ctl_r[0].a_y), .b_j (b_y_r),
    .a_k (ctl_r[0].a_z), .b_k (b_z_r),
    .s   (s_r), .val (lv0)
  );

  vfa_lane u_lane_y (
    .clk (clk), .op (ctl_r[0].op),
    .a_i (ctl_r[0].a_y), .b_i (b_y_r),
    .a_j (ctl_r[0].a_z), .b_j (b_z_r),
    .a_k (ctl_r[0].a_x), .b_k (b_x_r),
    .s   (s_r), .val (lv1)
  );

  vfa_lane u_lane_z (
    .clk (clk), .op (ctl_r[0].op),
    .a_i (ctl_r[0].a_z), .b_i (b_z_r),
    .a_j (ctl_r[0].a_x), .b_j (b_x_r),
    .a_k (ctl_r[0].a_y), .b_k (b_y_r),
    .s   (s_r), .val (lv2)
  );

  vfa_merge u_merge (
    .clk (clk), .op (ctl_r[2].op),
    .v0  (lv0), .v1 (lv1), .v2 (lv2),
    .bun (mrg_bun), .rad (rad)
  );

  vfa_sqrt u_sqrt (
    .clk (clk), .rad (rad), .root (root)
  );

  // Fold in the magnitude and the zero-vector check once the root is out
  assign rc = ctl_r[ROOT_IDX-1];
  assign abs_x = rc.a_x[CW-1] ? comp_t'(CW'(0) - rc.a_x) : rc.a_x;
  assign abs_y = rc.a_y[CW-1] ? comp_t'(CW'(0) - rc.a_y) : rc.a_y;
  assign abs_z = rc.a_z[CW-1] ? comp_t'(CW'(0) - rc.a_z) : rc.a_z;

  always_comb begin
    root_bun = bun_r[ROOT_IDX-1];
    if (rc.op == OP_MAG) begin
      root_bun.s  = root[CW-1] ? CMAX : comp_t'(root);
      root_bun.ov = root[CW-1];
    end else if (rc.op == OP_NORM && root == '0) begin
      root_bun.zv = 1'b1;
    end
  end

  // Advance the result bundle, replacing it at the root stage
  always_ff @(posedge clk) begin
    bun_r[5] <= mrg_bun;
    for (int k = 6; k <= LAST; k++) begin
      if (k == ROOT_IDX) begin
        bun_r[k] <= root_bun;
      end else begin
        bun_r[k] <= bun_r[k-1];
      end
    end
    num_r[0] <= {abs_x, {FB{1'b0}}};
    num_r[1] <= {abs_y, {FB{1'b0}}};
    num_r[2] <= {abs_z, {FB{1'b0}}};
    den_r    <= root;
  end

  for (genvar l = 0; l < 3; l++) begin : g_div
    vfa_div u_div (
      .clk (clk), .num (num_r[l]), .den (den_r), .quo (quo[l])
    );
  end

  // Sign and clamp the normalised components
  assign fx = sat_quot(quo[0], ctl_r[LAST].a_x[CW-1]);
  assign fy = sat_quot(quo[1], ctl_r[LAST].a_y[CW-1]);
  assign fz = sat_quot(quo[2], ctl_r[LAST].a_z[CW-1]);

  always_comb begin
    out_nxt = bun_r[LAST];
    if (ctl_r[LAST].op == OP_NORM && !bun_r[LAST].zv) begin
      out_nxt.x  = fx.val;
      out_nxt.y  = fy.val;
      out_nxt.z  = fz.val;
      out_nxt.ov = fx.ov | fy.ov | fz.ov;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_res_x       = out_r.x;
  assign out_res_y       = out_r.y;
  assign out_res_z       = out_r.z;
  assign out_res_scalar  = out_r.s;
  assign out_overflow    = out_r.ov;
  assign out_zero_vector = out_r.zv;

  // Every transfer produces exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LAT) out_valid)
    else $error("result missing after command transfer");

  // A zero-vector result carries zero components and no overflow
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_vector) |->
      (out_res_x == '0 && out_res_y == '0 && out_res_z == '0 &&
       out_res_scalar == '0 && !out_overflow))
    else $error("zero-vector result not cleared");

  // No result without a command that long ago
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[LAST]))
    else $error("result strobe without a command");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench of the three-component Q16.16 vector ALU.
`timescale 1ns / 1ps

module tb;
  import vfa_pkg::*;

  localparam int LATENCY  = 87;
  localparam int WD_LIMIT = 2000;
  localparam int N_RAND   = 640;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [2:0] op;
    comp_t ax, ay, az, bx, by, bz, sf;
  } vec_cmd_t;

  typedef struct {
    comp_t x, y, z, s;
    logic  ov, zv;
  } vec_res_t;

  typedef struct {
    vec_cmd_t cmd;
    logic     known;
    vec_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_op = '0;
  comp_t in_a_x = '0, in_a_y = '0, in_a_z = '0;
  comp_t in_b_x = '0, in_b_y = '0, in_b_z = '0;
  comp_t in_scale_factor = '0;
  logic out_valid;
  comp_t out_res_x, out_res_y, out_res_z, out_res_scalar;
  logic out_overflow, out_zero_vector;

  vec_res_t pending_results[$];
  int n_errors = 0;
  int idle_cycles = 0;

  vec3_fixed_point_alu_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_scale_factor(in_scale_factor),
    .out_valid(out_valid), .out_res_x(out_res_x), .out_res_y(out_res_y),
    .out_res_z(out_res_z), .out_res_scalar(out_res_scalar),
    .out_overflow(out_overflow), .out_zero_vector(out_zero_vector)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Clamp a wide signed value to the component range
  function automatic comp_t clamp_comp(input logic signed [131:0] v, inout logic ov);
    if (v > 132'sd2147483647) begin
      ov = 1'b1;
      return CMAX;
    end
    if (v < -132'sd2147483648) begin
      ov = 1'b1;
      return CMIN;
    end
    return comp_t'(v[31:0]);
  endfunction

  // Floor square root of an unsigned value, bit by bit
  function automatic logic [63:0] floor_sqrt(input logic [131:0] n);
    logic [131:0] root;
    logic [131:0] bitv;
    logic [131:0] t;
    root = '0;
    bitv = 132'd1 << 128;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      t = root + bitv;
      if (n >= t) begin
        n = n - t;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[63:0];
  endfunction

  // Compute the expected result of one operation
  function automatic vec_res_t vector_alu_result(input vec_cmd_t c);
    logic signed [131:0] a[3];
    logic signed [131:0] b[3];
    logic signed [131:0] s;
    logic signed [131:0] acc;
    logic signed [131:0] mag;
    logic signed [131:0] q;
    logic [63:0] m;
    comp_t r[3];
    vec_res_t e;
    int j, k;
    a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
    b[0] = c.bx; b[1] = c.by; b[2] = c.bz;
    s = c.sf;
    r = '{default: '0};
    e.s = '0; e.ov = 1'b0; e.zv = 1'b0;
    case (c.op)
      OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp_comp(a[i] + b[i], e.ov);
      OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp_comp(a[i] - b[i], e.ov);
      OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp_comp((a[i] * s) >>> FB, e.ov);
      OP_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        e.s = clamp_comp(acc >>> FB, e.ov);
      end
      OP_CROSS: for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        k = (i + 2) % 3;
        r[i] = clamp_comp((a[j] * b[k] - a[k] * b[j]) >>> FB, e.ov);
      end
      OP_MAG, OP_NORM: begin
        m = floor_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        mag = {68'd0, m};
        if (c.op == OP_MAG) begin
          e.s = clamp_comp(mag, e.ov);
        end else if (m == 0) begin
          e.zv = 1'b1;
        end else begin
          // truncate toward zero: divide the magnitude of the component
          for (int i = 0; i < 3; i++) begin
            q = ((a[i] < 0 ? -a[i] : a[i]) << FB) / mag;
            r[i] = clamp_comp(a[i] < 0 ? -q : q, e.ov);
          end
        end
      end
      default: ;
    endcase
    e.x = r[0]; e.y = r[1]; e.z = r[2];
    return e;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return CMAX;
      1: return CMIN;
      2: return comp_t'($urandom_range(0, 65535)) - comp_t'(32768);
      3: return comp_t'($signed($urandom) >>> $urandom_range(4, 20));
      4: return '0;
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic vec_cmd_t rand_cmd();
    vec_cmd_t c;
    c.op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
    c.ax = rand_comp(); c.ay = rand_comp(); c.az = rand_comp();
    c.bx = rand_comp(); c.by = rand_comp(); c.bz = rand_comp();
    c.sf = rand_comp();
    return c;
  endfunction

  // Present one command and hold it until the transfer
  task automatic send_cmd(input vec_cmd_t c, input vec_res_t e);
    start <= 1'b1;
    in_op <= c.op;
    in_a_x <= c.ax; in_a_y <= c.ay; in_a_z <= c.az;
    in_b_x <= c.bx; in_b_y <= c.by; in_b_z <= c.bz;
    in_scale_factor <= c.sf;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(e);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    vec_res_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result x=%0d", out_res_x);
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_res_x !== e.x) begin
          $error("res_x exp %0d got %0d", e.x, out_res_x); n_errors++;
        end
        if (out_res_y !== e.y) begin
          $error("res_y exp %0d got %0d", e.y, out_res_y); n_errors++;
        end
        if (out_res_z !== e.z) begin
          $error("res_z exp %0d got %0d", e.z, out_res_z); n_errors++;
        end
        if (out_res_scalar !== e.s) begin
          $error("res_scalar exp %0d got %0d", e.s, out_res_scalar); n_errors++;
        end
        if (out_overflow !== e.ov) begin
          $error("overflow exp %0b got %0b", e.ov, out_overflow); n_errors++;
        end
        if (out_zero_vector !== e.zv) begin
          $error("zero_vector exp %0b got %0b", e.zv, out_zero_vector); n_errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    vec_res_t e;
    vec_res_t zero_res;
    int burst;
    int gap;

    zero_res = '{x: '0, y: '0, z: '0, s: '0, ov: 1'b0, zv: 1'b0};
    // Directed table: known rows carry their result, the rest use the predictor
    row.known = 1'b0;
    row.cmd = '{OP_ADD, CMAX, CMIN, 32'sd65536, CMAX, CMIN, -32'sd65536, '0};
    rows.push_back(row);
    row.cmd = '{OP_SUB, CMIN, CMAX, '0, CMAX, CMIN, '0, '0};
    rows.push_back(row);
    row.cmd = '{OP_SCALE, CMAX, CMIN, 32'sd65536, '0, '0, '0, CMAX};
    rows.push_back(row);
    row.cmd = '{OP_SCALE, -32'sd3, 32'sd3, CMIN, '0, '0, '0, CMIN};
    rows.push_back(row);
    row.cmd = '{OP_DOT, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, '0};
    rows.push_back(row);
    row.cmd = '{OP_DOT, 32'sd65536, 32'sd131072, -32'sd1, 32'sd65536, 32'sd65536, 32'sd1, '0};
    rows.push_back(row);
    row.cmd = '{OP_CROSS, 32'sd65536, '0, '0, '0, 32'sd65536, '0, '0};
    rows.push_back(row);
    row.cmd = '{OP_CROSS, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, '0};
    rows.push_back(row);
    row.cmd = '{OP_MAG, CMIN, CMIN, CMIN, '0, '0, '0, '0};
    rows.push_back(row);
    row.cmd = '{OP_MAG, 32'sd196608, 32'sd262144, '0, '0, '0, '0, '0};
    rows.push_back(row);
    row.cmd = '{OP_NORM, 32'sd1, '0, '0, '0, '0, '0, '0};
    rows.push_back(row);
    row.cmd = '{OP_NORM, CMIN, 32'sd5, -32'sd7, '0, '0, '0, '0};
    rows.push_back(row);
    row.cmd = '{OP_NORM, -32'sd1, -32'sd1, -32'sd1, '0, '0, '0, '0};
    rows.push_back(row);
    // zero-vector normalize, unused opcode, saturating add/sub, zero magnitude
    row.known = 1'b1;
    row.cmd = '{OP_NORM, '0, '0, '0, CMAX, CMIN, CMAX, CMAX};
    row.res = zero_res;
    row.res.zv = 1'b1;
    rows.push_back(row);
    row.cmd = '{OP_UNUSED, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX};
    row.res = zero_res;
    rows.push_back(row);
    row.cmd = '{OP_ADD, CMAX, '0, '0, 32'sd1, '0, '0, '0};
    row.res = zero_res;
    row.res.x = CMAX;
    row.res.ov = 1'b1;
    rows.push_back(row);
    row.cmd = '{OP_SUB, CMIN, '0, '0, 32'sd1, '0, '0, '0};
    row.res = zero_res;
    row.res.x = CMIN;
    row.res.ov = 1'b1;
    rows.push_back(row);
    row.cmd = '{OP_MAG, '0, '0, '0, CMAX, CMAX, CMAX, CMAX};
    row.res = zero_res;
    rows.push_back(row);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      e = rows[i].known ? rows[i].res : vector_alu_result(rows[i].cmd);
      send_cmd(rows[i].cmd, e);
    end

    // Random bursts with random gaps between them
    burst = 0;
    for (int n = 0; n < N_RAND; n++) begin
      vec_cmd_t c;
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      c = rand_cmd();
      send_cmd(c, vector_alu_result(c));
      burst--;
    end
    start <= 1'b0;

    // Drain, then let the pipe settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
